// File: rtl/core/twrsm_pkg.sv
// Shared types and constants for the three-wire serial clock-chip master.
`timescale 1ns / 1ps
package twrsm_pkg;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Command byte bit that marks a read.
  localparam logic [7:0] ReadFlag = 8'h01;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } item_kind_e;

  // One classified item as it travels through the queue.
  typedef struct packed {
    item_kind_e kind;
    logic       is_read;
    logic [7:0] command;
    logic [7:0] data;
    logic       io_pin;
  } req_t;

endpackage

// File: rtl/core/twrsm_front.sv
// Front part: accept items, classify them and build the command byte.
`timescale 1ns / 1ps
module twrsm_front import twrsm_pkg::*; (
  input  logic       in_valid_i,
  input  logic       op_i,
  input  logic       is_read_i,
  input  logic [7:0] reg_address_i,
  input  logic [7:0] write_byte_i,
  input  logic       io_pin_i,
  input  logic       queue_full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output req_t       req_o
);

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i & ~queue_full_i;

  always_comb begin
    req_o.kind    = op_i ? KIND_START : KIND_TICK;
    req_o.is_read = is_read_i;
    // force the read flag into the command for reads
    req_o.command = is_read_i ? (reg_address_i | ReadFlag) : reg_address_i;
    req_o.data    = write_byte_i;
    req_o.io_pin  = io_pin_i;
  end

endmodule

// File: rtl/core/twrsm_queue.sv
// Short FIFO of classified items between the front and the back.
`timescale 1ns / 1ps
module twrsm_queue import twrsm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t req_i,
  input  logic pop_i,
  output logic full_o,
  output logic not_empty_o,
  output req_t req_o
);

  req_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_q, wptr_d;
  logic [QueuePtrW-1:0] rptr_q, rptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o      = (count_q == QueueCntW'(QueueDepth));
  assign not_empty_o = (count_q != '0);
  assign req_o       = mem_q[rptr_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & not_empty_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= req_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue count beyond depth");

endmodule

// File: rtl/core/twrsm_back.sv
// Back part: serial sequencer and output register.
`timescale 1ns / 1ps
module twrsm_back import twrsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       not_empty_i,
  input  req_t       req_i,
  output logic       pop_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic       chip_enable_o,
  output logic       serial_clock_o,
  output logic       io_out_o,
  output logic       io_drive_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] read_byte_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_OPEN   = 3'd1,
    PH_ENABLE = 3'd2,
    PH_SHIFT  = 3'd3,
    PH_READ   = 3'd4,
    PH_CLOSE  = 3'd5
  } phase_e;

  typedef struct packed {
    logic ce;
    logic sclk;
    logic io;
    logic drive;
  } pins_t;

  phase_e     phase_q, phase_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [1:0] sub_q, sub_d;
  logic       rd_mode_q, rd_mode_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] data_q, data_d;
  logic [7:0] acc_q, acc_d;
  pins_t      pins_q, pins_d;
  logic       done_d;
  logic       out_valid_q, out_valid_d;
  logic       ce_q, sclk_q, io_q, drive_q, busy_q, done_q;
  logic [7:0] rbyte_q;
  logic       pop;
  logic       tx_bit;
  logic [4:0] next_bit;

  function automatic pins_t make_pins(logic ce, logic sclk, logic io, logic drive);
    pins_t p;
    p.ce    = ce;
    p.sclk  = sclk;
    p.drive = drive;
    p.io    = drive & io;
    return p;
  endfunction

  // take the next item once the output slot is free or being emptied
  assign pop   = not_empty_i & (~out_valid_q | ~out_stall_i);
  assign pop_o = pop;

  assign tx_bit   = bit_cnt_q[3] ? data_q[bit_cnt_q[2:0]] : cmd_q[bit_cnt_q[2:0]];
  assign next_bit = {1'b0, bit_cnt_q} + 5'd1;

  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    sub_d     = sub_q;
    rd_mode_d = rd_mode_q;
    cmd_d     = cmd_q;
    data_d    = data_q;
    acc_d     = acc_q;
    pins_d    = pins_q;
    done_d    = 1'b0;
    if (pop) begin
      if (req_i.kind == KIND_START) begin
        if (phase_q == PH_IDLE) begin
          rd_mode_d = req_i.is_read;
          cmd_d     = req_i.command;
          data_d    = req_i.data;
          acc_d     = '0;
          bit_cnt_d = '0;
          sub_d     = '0;
          phase_d   = PH_OPEN;
        end
      end else begin
        unique case (phase_q)
          PH_OPEN: begin
            pins_d  = make_pins(1'b0, 1'b0, 1'b0, 1'b1);
            phase_d = PH_ENABLE;
          end
          PH_ENABLE: begin
            pins_d    = make_pins(1'b1, 1'b0, 1'b0, 1'b1);
            phase_d   = PH_SHIFT;
            bit_cnt_d = '0;
            sub_d     = '0;
          end
          PH_SHIFT: begin
            pins_d = make_pins(1'b1, ~sub_q[1], tx_bit, 1'b1);
            if (sub_q == 2'd3) begin
              sub_d     = '0;
              bit_cnt_d = next_bit[3:0];
              if (next_bit >= (rd_mode_q ? 5'd8 : 5'd16)) begin
                bit_cnt_d = '0;
                phase_d   = rd_mode_q ? PH_READ : PH_CLOSE;
              end
            end else begin
              sub_d = sub_q + 2'd1;
            end
          end
          PH_READ: begin
            if (sub_q == 2'd0) begin
              acc_d[bit_cnt_q[2:0]] = req_i.io_pin;
              pins_d = make_pins(1'b1, 1'b1, 1'b0, 1'b0);
              sub_d  = 2'd1;
            end else begin
              pins_d = make_pins(1'b1, 1'b0, 1'b0, 1'b0);
              sub_d  = '0;
              if (bit_cnt_q[2:0] == 3'd7) begin
                bit_cnt_d = '0;
                phase_d   = PH_CLOSE;
              end else begin
                bit_cnt_d = {1'b0, bit_cnt_q[2:0] + 3'd1};
              end
            end
          end
          PH_CLOSE: begin
            pins_d    = make_pins(1'b0, 1'b0, 1'b0, 1'b1);
            done_d    = 1'b1;
            phase_d   = PH_IDLE;
            bit_cnt_d = '0;
            sub_d     = '0;
          end
          default: begin
            pins_d    = make_pins(1'b0, 1'b0, 1'b0, 1'b1);
            phase_d   = PH_IDLE;
            bit_cnt_d = '0;
            sub_d     = '0;
          end
        endcase
      end
    end
    out_valid_d = pop | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= '0;
      sub_q       <= '0;
      rd_mode_q   <= 1'b0;
      cmd_q       <= '0;
      data_q      <= '0;
      acc_q       <= '0;
      pins_q      <= make_pins(1'b0, 1'b0, 1'b0, 1'b1);
      out_valid_q <= 1'b0;
      ce_q        <= 1'b0;
      sclk_q      <= 1'b0;
      io_q        <= 1'b0;
      drive_q     <= 1'b1;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      rbyte_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      sub_q       <= sub_d;
      rd_mode_q   <= rd_mode_d;
      cmd_q       <= cmd_d;
      data_q      <= data_d;
      acc_q       <= acc_d;
      pins_q      <= pins_d;
      out_valid_q <= out_valid_d;
      if (pop) begin
        ce_q    <= pins_d.ce;
        sclk_q  <= pins_d.sclk;
        io_q    <= pins_d.io;
        drive_q <= pins_d.drive;
        busy_q  <= (phase_d != PH_IDLE);
        done_q  <= done_d;
        rbyte_q <= acc_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chip_enable_o  = ce_q;
  assign serial_clock_o = sclk_q;
  assign io_out_o       = io_q;
  assign io_drive_o     = drive_q;
  assign busy_res_o     = busy_q;
  assign done_res_o     = done_q;
  assign read_byte_o    = rbyte_q;

  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> !busy_q)
    else $error("done reported while still busy");

  a_io_released_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !drive_q |-> !io_q)
    else $error("io level high while released");

  a_idle_ce_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> !pins_q.ce && !pins_q.sclk)
    else $error("chip enable or clock high while idle");

  a_read_no_drive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && req_i.kind == KIND_TICK && phase_q == PH_READ |=> !pins_q.drive)
    else $error("data pin driven during read phase");

endmodule

// File: rtl/core/three_wire_rtc_serial_master.sv
// Top level of the three-wire serial clock-chip master.
`timescale 1ns / 1ps
// Master for a three-wire serial clock chip (CE, SCLK, IO). Each input item is
// either a start request or a tick; every item returns exactly one result item
// carrying the pin levels after it, busy, a done pulse and the read byte. A
// start is taken only while idle (a start during a transfer is dropped but
// still answered). After a start, one tick gives CE and SCLK low, the next
// raises CE, then bits go out LSB first: four ticks per bit (SCLK high, high,
// low, low), 16 bits for a write (command then data) or 8 command bits for a
// read, which then releases IO and spends two ticks per received bit (sample
// and SCLK high, then SCLK low). A final tick drops CE and pulses done. For
// reads bit 0 of the command is forced high. Throughput is one item per clock
// cycle while the output is not stalled: the front classifies items into a
// two-entry queue; the back sequencer updates state and output per item taken.
// Each result is registered after the queue. in_stall_o rises only when the
// queue holds two items, i.e. after the output side has stalled.
module three_wire_rtc_serial_master import twrsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic       is_read_i,
  input  logic [7:0] reg_address_i,
  input  logic [7:0] write_byte_i,
  input  logic       io_pin_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       chip_enable_o,
  output logic       serial_clock_o,
  output logic       io_out_o,
  output logic       io_drive_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] read_byte_o
);

  // front to queue
  logic push;
  req_t push_req;
  logic q_full;
  // queue to back
  logic q_not_empty;
  req_t head_req;
  logic pop;

  twrsm_front u_front (
    .in_valid_i    (in_valid_i),
    .op_i          (op_i),
    .is_read_i     (is_read_i),
    .reg_address_i (reg_address_i),
    .write_byte_i  (write_byte_i),
    .io_pin_i      (io_pin_i),
    .queue_full_i  (q_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .req_o         (push_req)
  );

  twrsm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (push_req),
    .pop_i       (pop),
    .full_o      (q_full),
    .not_empty_o (q_not_empty),
    .req_o       (head_req)
  );

  // sequencer plus output register; it holds its result while stalled
  twrsm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .not_empty_i    (q_not_empty),
    .req_i          (head_req),
    .pop_o          (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .chip_enable_o  (chip_enable_o),
    .serial_clock_o (serial_clock_o),
    .io_out_o       (io_out_o),
    .io_drive_o     (io_drive_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .read_byte_o    (read_byte_o)
  );

endmodule
